// ----- hdl/edgf_pkg.sv -----
// ---------------------------------------------------------------------------
// edgf_pkg
// Shared types and constants of the encoder delta glitch filter.
// ---------------------------------------------------------------------------
package edgf_pkg;

	localparam int CHANNELS = 4;

	localparam int SAMPLE_W = 12;
	localparam int DELTA_W  = 13;
	localparam int CH_W     = 2;
	localparam int MISS_W   = 2;
	localparam int MASK_W   = 4;
	localparam int IDX_W    = 3;
	localparam int CFG_W    = 13;

	localparam logic [4:0] CHANNELS_W = 5'(CHANNELS);

	typedef enum logic {
		CMD_UPDATE = 1'b0,
		CMD_PRIME  = 1'b1
	} cmd_t;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_WRAP_LOW     = 3'd0;
	localparam logic [IDX_W-1:0] REG_WRAP_HIGH    = 3'd1;
	localparam logic [IDX_W-1:0] REG_JUMP_LIMIT   = 3'd2;
	localparam logic [IDX_W-1:0] REG_CHANGE_LIMIT = 3'd3;
	localparam logic [IDX_W-1:0] REG_MISS_LIMIT   = 3'd4;
	localparam logic [IDX_W-1:0] REG_INVERT_MASK  = 3'd5;

	localparam logic [11:0] RST_WRAP_LOW     = 12'h0FF;
	localparam logic [11:0] RST_WRAP_HIGH    = 12'h8FF;
	localparam logic [11:0] RST_JUMP_LIMIT   = 12'd150;
	localparam logic [12:0] RST_CHANGE_LIMIT = 13'd150;
	localparam logic [1:0]  RST_MISS_LIMIT   = 2'd2;
	localparam logic [3:0]  RST_INVERT_MASK  = 4'd10;

	typedef struct packed {
		logic [SAMPLE_W-1:0] wrap_low;
		logic [SAMPLE_W-1:0] wrap_high;
		logic [SAMPLE_W-1:0] jump_limit;
		logic [DELTA_W-1:0]  change_limit;
		logic [MISS_W-1:0]   miss_limit;
		logic [MASK_W-1:0]   invert_mask;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0]       prev;
		logic signed [DELTA_W-1:0] acc;
		logic [MISS_W-1:0]         miss;
	} chan_state_t;

	typedef struct packed {
		logic                      prev_we;
		logic                      filt_we;
		logic [CH_W-1:0]           ch;
		logic [SAMPLE_W-1:0]       prev;
		logic signed [DELTA_W-1:0] acc;
		logic                      acc_we;
		logic [MISS_W-1:0]         miss;
	} state_upd_t;

	typedef struct packed {
		logic signed [DELTA_W-1:0] delta;
		logic                      held;
		logic signed [DELTA_W-1:0] acc_next;
		logic                      acc_we;
		logic [MISS_W-1:0]         miss_next;
	} calc_res_t;

	function automatic logic [DELTA_W-1:0] abs13(input logic signed [DELTA_W-1:0] v);
		abs13 = v[DELTA_W-1] ? DELTA_W'(-v) : DELTA_W'(v);
	endfunction

endpackage

// ----- hdl/edgf_cfg.sv -----
// ---------------------------------------------------------------------------
// edgf_cfg
// Configuration registers, written through the configuration word channel.
// ---------------------------------------------------------------------------
module edgf_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [edgf_pkg::IDX_W-1:0] cfg_index,
	input  logic [edgf_pkg::CFG_W-1:0] cfg_data,
	output edgf_pkg::cfg_t            cfg
);
	import edgf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wrap_low     <= RST_WRAP_LOW;
			cfg_q.wrap_high    <= RST_WRAP_HIGH;
			cfg_q.jump_limit   <= RST_JUMP_LIMIT;
			cfg_q.change_limit <= RST_CHANGE_LIMIT;
			cfg_q.miss_limit   <= RST_MISS_LIMIT;
			cfg_q.invert_mask  <= RST_INVERT_MASK;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WRAP_LOW:     cfg_q.wrap_low     <= cfg_data[SAMPLE_W-1:0];
				REG_WRAP_HIGH:    cfg_q.wrap_high    <= cfg_data[SAMPLE_W-1:0];
				REG_JUMP_LIMIT:   cfg_q.jump_limit   <= cfg_data[SAMPLE_W-1:0];
				REG_CHANGE_LIMIT: cfg_q.change_limit <= cfg_data[DELTA_W-1:0];
				REG_MISS_LIMIT:   cfg_q.miss_limit   <= cfg_data[MISS_W-1:0];
				REG_INVERT_MASK:  cfg_q.invert_mask  <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/edgf_state.sv -----
// ---------------------------------------------------------------------------
// edgf_state
// Per-channel state: previous sample, last accepted delta and miss count.
// ---------------------------------------------------------------------------
module edgf_state (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [edgf_pkg::CH_W-1:0]  rd_ch,
	output edgf_pkg::chan_state_t      rd_state,
	input  edgf_pkg::state_upd_t       upd
);
	import edgf_pkg::*;

	logic [SAMPLE_W-1:0]       prev_q [CHANNELS];
	logic signed [DELTA_W-1:0] acc_q  [CHANNELS];
	logic [MISS_W-1:0]         miss_q [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				prev_q[i] <= '0;
				acc_q[i]  <= '0;
				miss_q[i] <= '0;
			end
		end else begin
			if (upd.prev_we)
				prev_q[upd.ch] <= upd.prev;
			if (upd.filt_we) begin
				miss_q[upd.ch] <= upd.miss;
				if (upd.acc_we)
					acc_q[upd.ch] <= upd.acc;
			end
		end
	end

	always_comb begin
		rd_state.prev = prev_q[rd_ch];
		rd_state.acc  = acc_q[rd_ch];
		rd_state.miss = miss_q[rd_ch];
	end

endmodule

// ----- hdl/edgf_calc.sv -----
// ---------------------------------------------------------------------------
// edgf_calc
// Delta with wrap detection, outlier rejection and output inversion.
// ---------------------------------------------------------------------------
module edgf_calc (
	input  logic [edgf_pkg::SAMPLE_W-1:0] sample,
	input  logic [edgf_pkg::CH_W-1:0]     ch,
	input  edgf_pkg::chan_state_t         st,
	input  edgf_pkg::cfg_t                cfg,
	output edgf_pkg::calc_res_t           res
);
	import edgf_pkg::*;

	localparam logic signed [14:0] FULL_SCALE = 15'sd4096;
	localparam logic signed [14:0] SAT_POS    = 15'sd4095;
	localparam logic signed [14:0] SAT_NEG    = -15'sd4095;

	logic signed [14:0]        s_x, p_x, d_raw, diff;
	logic                      wrap_up, wrap_dn, wrapped;
	logic signed [DELTA_W-1:0] d, sel;
	logic [DELTA_W-1:0]        abs_d, abs_a;
	logic [13:0]               abs_diff;
	logic [15:0]               five_d, jump_bound;
	logic                      can_miss, held;

	always_comb begin
		s_x = $signed({3'b000, sample});
		p_x = $signed({3'b000, st.prev});
		wrap_up = (sample < cfg.wrap_low) && (st.prev > cfg.wrap_high);
		wrap_dn = (sample > cfg.wrap_high) && (st.prev < cfg.wrap_low);
		wrapped = wrap_up || wrap_dn;

		if (wrap_up)
			d_raw = s_x - p_x + FULL_SCALE;
		else if (wrap_dn)
			d_raw = s_x - p_x - FULL_SCALE;
		else
			d_raw = s_x - p_x;

		// saturate wraps that odd thresholds push past full scale
		if (d_raw > SAT_POS)
			d = DELTA_W'(SAT_POS);
		else if (d_raw < SAT_NEG)
			d = DELTA_W'(SAT_NEG);
		else
			d = DELTA_W'(d_raw);

		abs_d = abs13(d);
		abs_a = abs13(st.acc);
		// 5*|d| > 5*jump + |a| keeps the fifth exact
		five_d     = {1'b0, abs_d, 2'b00} + {3'b000, abs_d};
		jump_bound = {2'b00, cfg.jump_limit, 2'b00} + {4'b0000, cfg.jump_limit}
			+ {3'b000, abs_a};

		diff = 15'(d) - 15'(st.acc);
		abs_diff = diff[14] ? 14'(-diff) : 14'(diff);

		can_miss = st.miss < cfg.miss_limit;
		held = can_miss && ((!wrapped && (five_d > jump_bound))
			|| (abs_diff > {1'b0, cfg.change_limit}));

		sel = held ? st.acc : d;
		res.delta     = cfg.invert_mask[ch] ? -sel : sel;
		res.held      = held;
		res.acc_next  = d;
		res.acc_we    = !held;
		res.miss_next = held ? st.miss + 2'd1 : '0;
	end

endmodule

// ----- hdl/encoder_delta_glitch_filter_top.sv -----
// ---------------------------------------------------------------------------
// encoder_delta_glitch_filter_top
// Unwraps 12-bit absolute encoder samples into filtered per-channel deltas.
// ---------------------------------------------------------------------------
// Usage:
//  Input words (command, channel, sample) are taken on in_valid while
//  in_stall is low. An update word yields one result word (delta,
//  out_channel, held) on out_valid; a prime word only loads the channel's
//  previous sample and yields nothing.
//  Path: a word taken in passes the input register, then the filter and the
//  result register, before it reaches the output.
//  Throughput: one word per cycle while no out_stall holds an update word;
//  state for the channel is read and written back in the same cycle, so
//  words for the same channel may follow back to back.
//  When the receiver raises out_stall the result register holds; the input
//  register still drains prime words, and in_stall rises once an update
//  word waits behind the held result.
//  Reset clears all channel state and loads the register defaults.
//  Configuration writes are always ready and should be made while idle.
// ---------------------------------------------------------------------------
module encoder_delta_glitch_filter_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [edgf_pkg::IDX_W-1:0]        cfg_index,
	input  logic [edgf_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              command,
	input  logic [edgf_pkg::CH_W-1:0]         channel,
	input  logic [edgf_pkg::SAMPLE_W-1:0]     sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [edgf_pkg::DELTA_W-1:0] delta,
	output logic [edgf_pkg::CH_W-1:0]         out_channel,
	output logic                              held
);
	import edgf_pkg::*;

	cfg_t        cfg;
	chan_state_t st;
	state_upd_t  upd;
	calc_res_t   res;

	logic                      valid_s1;
	cmd_t                      command_s1;
	logic [CH_W-1:0]           channel_s1;
	logic [SAMPLE_W-1:0]       sample_s1;
	logic                      out_valid_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic [CH_W-1:0]           out_channel_q;
	logic                      held_q;

	logic present, emits, advance, accept_in;

	assign cfg_ready = 1'b1;

	edgf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	edgf_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_ch    (channel_s1),
		.rd_state (st),
		.upd      (upd)
	);

	edgf_calc u_calc (
		.sample (sample_s1),
		.ch     (channel_s1),
		.st     (st),
		.cfg    (cfg),
		.res    (res)
	);

	always_comb begin
		present   = {3'b000, channel_s1} < CHANNELS_W;
		emits     = valid_s1 && present && (command_s1 == CMD_UPDATE);
		// pass words that make no result at once; otherwise wait for room at the output
		advance   = valid_s1 && (!emits || !out_valid_q || !out_stall);
		in_stall  = valid_s1 && !advance;
		accept_in = in_valid && !in_stall;

		upd.prev_we = advance && present;
		upd.filt_we = advance && emits;
		upd.ch      = channel_s1;
		upd.prev    = sample_s1;
		upd.acc     = res.acc_next;
		upd.acc_we  = res.acc_we;
		upd.miss    = res.miss_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept_in)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;

			if (advance && emits)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			command_s1 <= cmd_t'(command);
			channel_s1 <= channel;
			sample_s1  <= sample;
		end
		if (advance && emits) begin
			delta_q       <= res.delta;
			out_channel_q <= channel_s1;
			held_q        <= res.held;
		end
	end

	assign out_valid   = out_valid_q;
	assign delta       = delta_q;
	assign out_channel = out_channel_q;
	assign held        = held_q;

endmodule
